// ===== hw/rtl/chpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Column histogram peak finder package
// Shared widths, reset values, register indexes and size limits.
// ----------------------------------------------------------------------------
package chpf_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int MAX_HEIGHT_DEFAULT = 1024;

  localparam int PIXEL_W     = 8;
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int COUNT_W     = 10;
  localparam int PEAK_COL_W  = 11;

  localparam logic [PIXEL_W-1:0] LANE_VALUE = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 10'd1023;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
  localparam int               MIN_SIZE     = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

endpackage

// ===== hw/rtl/chpf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module chpf_ram #(
  parameter int WIDTH = chpf_pkg::COUNT_W,
  parameter int DEPTH = chpf_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     write_enable,
  input  logic [$clog2(DEPTH)-1:0] write_address,
  input  logic [WIDTH-1:0]         write_data,
  input  logic [$clog2(DEPTH)-1:0] read_address,
  output logic [WIDTH-1:0]         read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_enable) begin
      mem[write_address] <= write_data;
    end
    read_data <= mem[read_address];
  end

endmodule

// ===== hw/rtl/column_histogram_peak_finder_core.sv =====
// A result is registered at the output after the last pixel passes the s1 stage.
// Throughput: one pixel per cycle, set by the read-modify-write of the count memory.
// At the frame end the last pixel waits while the previous result is still unread.
// Reset clears the positions and the output flag and loads 640 by 480; the count
// memory needs no clearing, since row 0 of every frame overwrites each column.
// ----------------------------------------------------------------------------
// Column histogram peak finder core
// Counts lane pixels per column in the bottom half of each frame and reports
// the peak column and count of the left and right image halves.
// ----------------------------------------------------------------------------
module column_histogram_peak_finder_core #(
  parameter int MAX_WIDTH  = chpf_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = chpf_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [chpf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [chpf_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   pixel_valid,
  output logic                                   pixel_stall,
  input  logic [chpf_pkg::PIXEL_W-1:0]           pixel,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [chpf_pkg::PEAK_COL_W-1:0] left_peak_column,
  output logic signed [chpf_pkg::PEAK_COL_W-1:0] right_peak_column,
  output logic [chpf_pkg::COUNT_W-1:0]           left_peak_count,
  output logic [chpf_pkg::COUNT_W-1:0]           right_peak_count
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WZ  = $clog2(MAX_WIDTH + 1);
  localparam int HZ  = $clog2(MAX_HEIGHT + 1);
  localparam int WXW = (WZ > chpf_pkg::CFG_W) ? WZ : chpf_pkg::CFG_W;
  localparam int HXW = (HZ > chpf_pkg::CFG_W) ? HZ : chpf_pkg::CFG_W;
  localparam int NW  = chpf_pkg::COUNT_W;

  logic [chpf_pkg::CFG_W-1:0] frame_width;
  logic [chpf_pkg::CFG_W-1:0] frame_height;

  logic [WXW-1:0] fw_x;
  logic [HXW-1:0] fh_x;
  logic [WXW-1:0] eff_w;
  logic [HXW-1:0] eff_h;
  logic [CW-1:0]  w_last;
  logic [CW-1:0]  w_half;
  logic [RW-1:0]  h_last;
  logic [RW-1:0]  h_half;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic          pixel_take;
  logic          last_pos;

  logic          s1_valid;
  logic [CW-1:0] s1_col;
  logic          s1_clear;
  logic          s1_inc;
  logic          s1_last_row;
  logic          s1_first_col;
  logic          s1_left;
  logic          s1_emit;

  logic [NW-1:0] ram_rdata;
  logic [NW-1:0] cnt_base;
  logic [NW-1:0] cnt_new;

  logic [NW-1:0] left_cnt;
  logic [CW-1:0] left_col;
  logic [NW-1:0] right_cnt;
  logic [CW-1:0] right_col;
  logic [NW-1:0] left_cnt_base;
  logic [NW-1:0] right_cnt_base;
  logic [NW-1:0] left_cnt_next;
  logic [CW-1:0] left_col_next;
  logic [NW-1:0] right_cnt_next;
  logic [CW-1:0] right_col_next;

  // Effective frame size after clamping into the supported range.
  always_comb begin
    fw_x = WXW'(frame_width);
    fh_x = HXW'(frame_height);
    if (fw_x < WXW'(chpf_pkg::MIN_SIZE)) begin
      eff_w = WXW'(chpf_pkg::MIN_SIZE);
    end else if (fw_x > WXW'(MAX_WIDTH)) begin
      eff_w = WXW'(MAX_WIDTH);
    end else begin
      eff_w = fw_x;
    end
    if (fh_x < HXW'(chpf_pkg::MIN_SIZE)) begin
      eff_h = HXW'(chpf_pkg::MIN_SIZE);
    end else if (fh_x > HXW'(MAX_HEIGHT)) begin
      eff_h = HXW'(MAX_HEIGHT);
    end else begin
      eff_h = fh_x;
    end
    w_last = CW'(eff_w - WXW'(1));
    w_half = CW'(eff_w >> 1);
    h_last = RW'(eff_h - HXW'(1));
    h_half = RW'(eff_h >> 1);
  end

  assign last_pos    = (col == w_last) && (row == h_last);
  assign pixel_stall = last_pos && result_valid && result_stall;
  assign pixel_take  = pixel_valid && !pixel_stall;

  always_comb begin
    col_next = col;
    row_next = row;
    if (pixel_take) begin
      if (col == w_last) begin
        col_next = '0;
        row_next = (row == h_last) ? '0 : row + RW'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= chpf_pkg::WIDTH_RESET;
      frame_height <= chpf_pkg::HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        chpf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        chpf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pixel_take;
    end
    s1_col       <= col;
    s1_clear     <= (row == '0);
    s1_inc       <= (row >= h_half) && (pixel == chpf_pkg::LANE_VALUE);
    s1_last_row  <= (row == h_last);
    s1_first_col <= (col == '0);
    s1_left      <= (col < w_half);
    s1_emit      <= last_pos;
  end

  chpf_ram #(
    .WIDTH(NW),
    .DEPTH(MAX_WIDTH)
  ) u_count_ram (
    .clk          (clk),
    .write_enable (s1_valid),
    .write_address(s1_col),
    .write_data   (cnt_new),
    .read_address (col),
    .read_data    (ram_rdata)
  );

  assign cnt_base = s1_clear ? '0 : ram_rdata;
  assign cnt_new  = (s1_inc && (cnt_base != chpf_pkg::COUNT_MAX)) ? cnt_base + NW'(1)
                                                                 : cnt_base;

  always_comb begin
    left_cnt_base  = s1_first_col ? '0 : left_cnt;
    right_cnt_base = s1_first_col ? '0 : right_cnt;
    left_cnt_next  = left_cnt_base;
    left_col_next  = left_col;
    right_cnt_next = right_cnt_base;
    right_col_next = right_col;
    if (s1_left) begin
      if (cnt_new > left_cnt_base) begin
        left_cnt_next = cnt_new;
        left_col_next = s1_col;
      end
    end else if (cnt_new > right_cnt_base) begin
      right_cnt_next = cnt_new;
      right_col_next = s1_col;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_last_row) begin
      left_cnt  <= left_cnt_next;
      left_col  <= left_col_next;
      right_cnt <= right_cnt_next;
      right_col <= right_col_next;
    end
  end

  // A zero count means no lane pixel in that half, reported as column -1.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_valid && s1_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (s1_valid && s1_emit) begin
      left_peak_count   <= left_cnt_next;
      right_peak_count  <= right_cnt_next;
      left_peak_column  <= (left_cnt_next == '0) ? '1 : chpf_pkg::PEAK_COL_W'(left_col_next);
      right_peak_column <= (right_cnt_next == '0) ? '1
                                                  : chpf_pkg::PEAK_COL_W'(right_col_next);
    end
  end

  a_no_same_column_overlap: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && pixel_take) |-> (s1_col != col))
    else $error("Count memory read and write hit the same column.");

  a_emit_into_free_output: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit) |-> !(result_valid && result_stall))
    else $error("A result was produced while the output still held one.");

  a_last_pixel_emits: assert property (@(posedge clk) disable iff (rst)
    (pixel_take && last_pos && !cfg_write) |=> (s1_valid && s1_emit))
    else $error("The last pixel of a frame did not lead to a result.");

  a_position_in_frame: assert property (@(posedge clk) disable iff (rst)
    (col <= w_last) && (row <= h_last))
    else $error("Pixel position left the frame.");

endmodule
